// File: design/tcgw_pkg.sv
// package for the text console grid writer
// holds shared constants, request codes, state encoding and the queue word
// used by every other file of the block but tcgw_if
package tcgw_pkg;

   // grid size defaults
   localparam int ROWS_DEF = 25;
   localparam int COLS_DEF = 80;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_NORMAL_ATTR = 1'b0;

   // character and attribute constants
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] RESET_ATTR = 8'h07;
   localparam logic [7:0] BOLD_MASK  = 8'h08;

   // request codes
   typedef enum logic [2:0] {
      OP_PUT_CURSOR = 3'd0,
      OP_PUT_CELL   = 3'd1,
      OP_ERASE      = 3'd2,
      OP_READ       = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_FILL       = 3'd5,
      OP_SET_PEN    = 3'd6
   } op_type;

   // back end sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_STORE,
      ST_ERASE,
      ST_RD_DATA,
      ST_SWEEP,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_SCR_BLANK,
      ST_DONE
   } back_state_type;

   // classified request word in the queue
   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] char_code;
      logic [7:0] attr_byte;
      logic       bold;
      logic [5:0] cell_row;
      logic [6:0] cell_col;
      logic [7:0] erase_count;
      logic       printable;
      logic       in_grid;
      logic       is_newline;
      logic       is_tab;
   } item_type;

   // back end to front end
   typedef struct packed {
      logic init_busy;
      logic pop;
   } back_status_type;

   function automatic logic storable(input logic [7:0] c);
      storable = (c >= 8'h20 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'h8E);
   endfunction

endpackage

// File: design/tcgw_if.sv
// channel interfaces for the text console grid writer
// request and response channels, valid/ready handshake
interface cons_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] char_code;
   logic [7:0] attr_byte;
   logic       bold;
   logic [5:0] cell_row;
   logic [6:0] cell_col;
   logic [7:0] erase_count;

   modport source (output valid, req_type, char_code, attr_byte, bold, cell_row,
                   cell_col, erase_count, input ready);
   modport sink (input valid, req_type, char_code, attr_byte, bold, cell_row,
                 cell_col, erase_count, output ready);
endinterface

interface cons_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_char;
   logic [7:0] read_attr;
   logic [5:0] cursor_row;
   logic [7:0] cursor_col;

   modport source (output valid, read_char, read_attr, cursor_row, cursor_col,
                   input ready);
   modport sink (input valid, read_char, read_attr, cursor_row, cursor_col,
                 output ready);
endinterface

// File: design/tcgw_front.sv
// front end: accepts request words, classifies them, two-entry queue
// depends on tcgw_pkg and cons_req_if
module tcgw_front import tcgw_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   cons_req_if.sink        req_port,
   input  back_status_type status,
   output logic            item_valid,
   output item_type        item
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   cls;

   // classify the incoming word
   always_comb begin
      cls.req_type    = req_port.req_type;
      cls.char_code   = req_port.char_code;
      cls.attr_byte   = req_port.attr_byte;
      cls.bold        = req_port.bold;
      cls.cell_row    = req_port.cell_row;
      cls.cell_col    = req_port.cell_col;
      cls.erase_count = req_port.erase_count;
      cls.printable   = storable(req_port.char_code);
      cls.in_grid     = (32'(req_port.cell_row) < 32'(ROWS)) &&
                        (32'(req_port.cell_col) < 32'(COLS));
      cls.is_newline  = (req_port.char_code == CH_NEWLINE);
      cls.is_tab      = (req_port.char_code == CH_TAB);
   end

   assign req_port.ready = !status.init_busy && (count_ff != 2'd2);
   assign push = req_port.valid && req_port.ready;
   assign item_valid = (count_ff != 2'd0);
   assign item = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ status.pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, status.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// File: design/tcgw_back.sv
// back end: grid memory and sequencer that carries out one request at a time
// depends on tcgw_pkg and cons_rsp_if
module tcgw_back import tcgw_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      normal_attr,
   input  logic            item_valid,
   input  item_type        item,
   output back_status_type status,
   cons_rsp_if.source      rsp_port
);

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
   localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(CELLS - COLS);
   localparam logic [5:0]        LAST_ROW  = 6'(ROWS - 1);
   localparam logic [7:0]        COLS_C    = 8'(COLS);

   logic [15:0] mem [CELLS];
   logic [15:0] rdata_ff;
   logic [ADDR_W-1:0] raddr, waddr;
   logic [15:0] wdata;
   logic we;

   back_state_type st_ff, st_in;
   logic [5:0]        row_ff, row_in;
   logic [7:0]        col_ff, col_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [7:0]        pen_ff, pen_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic              resume_ff, resume_in;
   logic              tab_ff, tab_in;
   logic [15:0]       word_ff, word_in;
   logic [7:0]        rc_ff, rc_in;
   logic [7:0]        ra_ff, ra_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_char_ff, out_char_in;
   logic [7:0]        out_attr_ff, out_attr_in;
   logic [5:0]        out_row_ff, out_row_in;
   logic [7:0]        out_col_ff, out_col_in;
   logic              pop;
   logic [7:0]        col_next;
   logic [7:0]        put_attr;

   assign col_next = col_ff + 8'd1;
   assign put_attr = item.bold ? (pen_ff | BOLD_MASK) : pen_ff;

   // sequencer
   always_comb begin
      st_in        = st_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      base_in      = base_ff;
      pen_in       = pen_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      resume_in    = resume_ff;
      tab_in       = tab_ff;
      word_in      = word_ff;
      rc_in        = rc_ff;
      ra_in        = ra_ff;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      out_char_in  = out_char_ff;
      out_attr_in  = out_attr_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      pop          = 1'b0;
      we           = 1'b0;
      waddr        = idx_ff;
      wdata        = word_ff;
      raddr        = idx_ff;
      case (st_ff)
         ST_INIT: begin
            we    = 1'b1;
            wdata = {CH_SPACE, RESET_ATTR};
            if (idx_ff == LAST_CELL) begin
               idx_in = '0;
               st_in  = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            raddr = ADDR_W'(32'(item.cell_row) * COLS + 32'(item.cell_col));
            if (item_valid && !out_valid_ff) begin
               pop   = 1'b1;
               rc_in = 8'd0;
               ra_in = 8'd0;
               st_in = ST_DONE;
               case (op_type'(item.req_type))
                  OP_PUT_CURSOR: begin
                     tab_in  = item.is_tab;
                     word_in = {item.is_tab ? CH_SPACE : item.char_code, put_attr};
                     if (item.is_newline) begin
                        col_in = 8'd0;
                        if (row_ff == LAST_ROW) begin
                           resume_in = 1'b0;
                           idx_in    = COLS_A;
                           st_in     = ST_SCR_RD;
                        end else begin
                           row_in  = row_ff + 6'd1;
                           base_in = base_ff + COLS_A;
                        end
                     end else if (item.is_tab || item.printable) begin
                        st_in = ST_STORE;
                     end
                  end
                  OP_PUT_CELL: begin
                     if (item.printable && item.in_grid) begin
                        we    = 1'b1;
                        waddr = raddr;
                        wdata = {item.char_code, item.attr_byte};
                     end
                  end
                  OP_ERASE: begin
                     cnt_in = item.erase_count;
                     st_in  = ST_ERASE;
                  end
                  OP_READ: begin
                     if (item.in_grid) begin
                        st_in = ST_RD_DATA;
                     end else begin
                        ra_in = normal_attr;
                     end
                  end
                  OP_CLEAR: begin
                     word_in = {CH_SPACE, normal_attr};
                     pen_in  = normal_attr;
                     row_in  = 6'd0;
                     col_in  = 8'd0;
                     base_in = '0;
                     idx_in  = '0;
                     st_in   = ST_SWEEP;
                  end
                  OP_FILL: begin
                     word_in = {item.char_code, item.attr_byte};
                     row_in  = 6'd0;
                     col_in  = 8'd0;
                     base_in = '0;
                     idx_in  = '0;
                     if (item.printable) begin
                        st_in = ST_SWEEP;
                     end
                  end
                  OP_SET_PEN: begin
                     pen_in = item.attr_byte;
                  end
                  default: begin
                     st_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_STORE: begin
            if (col_ff >= COLS_C) begin
               // deferred wrap before the store
               col_in = 8'd0;
               if (row_ff == LAST_ROW) begin
                  resume_in = 1'b1;
                  idx_in    = COLS_A;
                  st_in     = ST_SCR_RD;
               end else begin
                  row_in  = row_ff + 6'd1;
                  base_in = base_ff + COLS_A;
               end
            end else begin
               we     = 1'b1;
               waddr  = base_ff + ADDR_W'(col_ff);
               col_in = col_next;
               if (!tab_ff || col_next[2:0] == 3'd0) begin
                  st_in = ST_DONE;
               end
            end
         end
         ST_ERASE: begin
            if (cnt_ff != 8'd0 && col_ff != 8'd0) begin
               we     = 1'b1;
               waddr  = base_ff + ADDR_W'(col_ff - 8'd1);
               wdata  = {CH_SPACE, pen_ff};
               col_in = col_ff - 8'd1;
               cnt_in = cnt_ff - 8'd1;
            end else begin
               st_in = ST_DONE;
            end
         end
         ST_RD_DATA: begin
            rc_in = rdata_ff[15:8];
            ra_in = rdata_ff[7:0];
            st_in = ST_DONE;
         end
         ST_SWEEP: begin
            we = 1'b1;
            if (idx_ff == LAST_CELL) begin
               st_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCR_RD: begin
            st_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            // move one cell up a row
            we    = 1'b1;
            waddr = idx_ff - COLS_A;
            wdata = rdata_ff;
            if (idx_ff == LAST_CELL) begin
               idx_in = LAST_BASE;
               st_in  = ST_SCR_BLANK;
            end else begin
               idx_in = idx_ff + 1'b1;
               st_in  = ST_SCR_RD;
            end
         end
         ST_SCR_BLANK: begin
            we    = 1'b1;
            wdata = {CH_SPACE, pen_ff};
            if (idx_ff == LAST_CELL) begin
               row_in  = LAST_ROW;
               base_in = LAST_BASE;
               st_in   = resume_ff ? ST_STORE : ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            out_valid_in = 1'b1;
            out_char_in  = rc_ff;
            out_attr_in  = ra_ff;
            out_row_in   = row_ff;
            out_col_in   = col_ff;
            st_in        = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_INIT;
         row_ff       <= 6'd0;
         col_ff       <= 8'd0;
         base_ff      <= '0;
         pen_ff       <= RESET_ATTR;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         pen_ff       <= pen_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      resume_ff   <= resume_in;
      tab_ff      <= tab_in;
      word_ff     <= word_in;
      rc_ff       <= rc_in;
      ra_ff       <= ra_in;
      out_char_ff <= out_char_in;
      out_attr_ff <= out_attr_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
   end

   // grid memory, character in the high byte
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign status.init_busy = (st_ff == ST_INIT);
   assign status.pop       = pop;

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.read_char  = out_char_ff;
   assign rsp_port.read_attr  = out_attr_ff;
   assign rsp_port.cursor_row = out_row_ff;
   assign rsp_port.cursor_col = out_col_ff;

endmodule

// File: design/text_console_grid_writer.sv
// top level of the text console grid writer
// depends on tcgw_pkg, cons_req_if, cons_rsp_if, tcgw_front and tcgw_back
//
//  channel   dir  handshake            word
//  req_port  in   valid/ready          one request
//  rsp_port  out  valid/ready          read data and cursor after the request
//  csr_*     in   apb, pready high     normal_attr at byte address 0
//
// after reset a clearing pass writes every cell, with no request taken. each
// request is carried out from the queue to its result one at a time; cursor
// puts, tabs, erases, clears and fills write one cell at a time, a read, an
// erase's last check or a deferred wrap takes a step more, and a scroll reads
// and writes each cell in turn. the next word starts in the cycle after the
// result is taken. a two-word queue takes requests while one is worked on, and
// the result register waits for rsp_port.ready.
module text_console_grid_writer import tcgw_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   cons_req_if.sink          req_port,
   cons_rsp_if.source        rsp_port,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [7:0]      normal_attr_ff, normal_attr_in;
   logic            item_valid;
   item_type        item;
   back_status_type status;

   // configuration register
   assign csr_pready = 1'b1;
   always_comb begin
      normal_attr_in = normal_attr_ff;
      if (csr_psel && csr_penable && csr_pwrite &&
          csr_paddr[CSR_AW-1] == REG_NORMAL_ATTR) begin
         normal_attr_in = csr_pwdata[7:0];
      end
   end
   assign csr_prdata = (csr_paddr[CSR_AW-1] == REG_NORMAL_ATTR) ?
                       {{(CSR_DW-8){1'b0}}, normal_attr_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_attr_ff <= RESET_ATTR;
      end else begin
         normal_attr_ff <= normal_attr_in;
      end
   end

   tcgw_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .status     (status),
      .item_valid (item_valid),
      .item       (item)
   );

   tcgw_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .normal_attr (normal_attr_ff),
      .item_valid  (item_valid),
      .item        (item),
      .status      (status),
      .rsp_port    (rsp_port)
   );

endmodule

// File: tb/tb_top.sv
// testbench for the text console grid writer
// predicts every response from its own model of the grid, cursor and pen
// depends on tcgw_pkg, cons_req_if, cons_rsp_if and text_console_grid_writer
module tb_top;
   import tcgw_pkg::*;

   localparam int NROW = 25;
   localparam int NCOL = 80;
   localparam int NCELL = NROW * NCOL;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic [7:0] at;
      logic       bold;
      logic [5:0] row;
      logic [6:0] col;
      logic [7:0] cnt;
   } console_req_type;

   typedef struct packed {
      logic [7:0] rd_char;
      logic [7:0] rd_attr;
      logic [5:0] crow;
      logic [7:0] ccol;
   } console_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   cons_req_if req_bus();
   cons_rsp_if rsp_bus();

   text_console_grid_writer #(.ROWS(NROW), .COLS(NCOL)) i_dut (
      .clock(clock), .reset(reset), .req_port(req_bus.sink),
      .rsp_port(rsp_bus.source), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready));

   // shadow console state
   logic [7:0] grid_ch [NCELL];
   logic [7:0] grid_at [NCELL];
   int unsigned crs_row, crs_col;
   logic [7:0] pen, normal;

   console_req_type pending_reqs[$];
   console_rsp_type expected_rsps[$];
   int errors = 0;
   int accepted = 0, checked = 0;
   bit idle_on = 1'b1;
   bit hold_rsp = 1'b0;

   function automatic bit printable(logic [7:0] c);
      return (c >= 8'h20 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'h8E);
   endfunction

   function automatic void poke(int unsigned r, int unsigned c, logic [7:0] ch,
                                logic [7:0] at);
      if (r < NROW && c < NCOL) begin
         grid_ch[r*NCOL+c] = ch;
         grid_at[r*NCOL+c] = at;
      end
   endfunction

   // advance a line, scrolling up with a pen-colored blank row at the bottom
   function automatic void line_feed();
      crs_col = 0;
      if (crs_row + 1 >= NROW) begin
         for (int i = NCOL; i < NCELL; i++) begin
            grid_ch[i-NCOL] = grid_ch[i];
            grid_at[i-NCOL] = grid_at[i];
         end
         for (int i = 0; i < NCOL; i++) poke(NROW-1, i, CH_SPACE, pen);
         crs_row = NROW - 1;
      end else begin
         crs_row++;
      end
   endfunction

   function automatic void store_char(logic [7:0] ch, logic [7:0] at);
      if (crs_col >= NCOL) line_feed();
      poke(crs_row, crs_col, ch, at);
      crs_col++;
   endfunction

   function automatic console_rsp_type console_apply(console_req_type q);
      console_rsp_type r;
      logic [7:0] at;
      int n;
      r = '0;
      case (q.kind)
         OP_PUT_CURSOR: begin
            at = q.bold ? (pen | BOLD_MASK) : pen;
            if (q.ch == CH_NEWLINE) line_feed();
            else if (q.ch == CH_TAB) begin
               do store_char(CH_SPACE, at); while (crs_col % 8 != 0);
            end else if (printable(q.ch)) store_char(q.ch, at);
         end
         OP_PUT_CELL: if (printable(q.ch)) poke(q.row, q.col, q.ch, q.at);
         OP_ERASE: begin
            n = q.cnt;
            while (n != 0 && crs_col != 0) begin
               n--;
               crs_col--;
               poke(crs_row, crs_col, CH_SPACE, pen);
            end
         end
         OP_READ: begin
            if (q.row < NROW && q.col < NCOL) begin
               r.rd_char = grid_ch[q.row*NCOL+q.col];
               r.rd_attr = grid_at[q.row*NCOL+q.col];
            end else begin
               r.rd_attr = normal;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < NCELL; i++) begin
               grid_ch[i] = CH_SPACE;
               grid_at[i] = normal;
            end
            pen = normal;
            crs_row = 0;
            crs_col = 0;
         end
         OP_FILL: begin
            if (printable(q.ch))
               for (int i = 0; i < NCELL; i++) begin
                  grid_ch[i] = q.ch;
                  grid_at[i] = q.at;
               end
            crs_row = 0;
            crs_col = 0;
         end
         OP_SET_PEN: pen = q.at;
         default: ;
      endcase
      r.crow = crs_row[5:0];
      r.ccol = crs_col[7:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      $display("mismatch on response %0d: %s got %0h expected %0h", checked, what,
               got, want);
   endtask

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // request driver
   console_req_type cur;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            accepted++;
            expected_rsps.push_back(console_apply(cur));
         end
         if (pending_reqs.size() != 0 && !(idle_on && $urandom_range(99) < 34)) begin
            cur = pending_reqs.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.req_type <= cur.kind;
            req_bus.char_code <= cur.ch;
            req_bus.attr_byte <= cur.at;
            req_bus.bold <= cur.bold;
            req_bus.cell_row <= cur.row;
            req_bus.cell_col <= cur.col;
            req_bus.erase_count <= cur.cnt;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor
   console_rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("response word with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_bus.read_char !== want.rd_char)
                  report_mismatch("read_char", rsp_bus.read_char, want.rd_char);
               if (rsp_bus.read_attr !== want.rd_attr)
                  report_mismatch("read_attr", rsp_bus.read_attr, want.rd_attr);
               if (rsp_bus.cursor_row !== want.crow)
                  report_mismatch("cursor_row", {2'b0, rsp_bus.cursor_row},
                                  {2'b0, want.crow});
               if (rsp_bus.cursor_col !== want.ccol)
                  report_mismatch("cursor_col", rsp_bus.cursor_col, want.ccol);
            end
            checked++;
         end
         rsp_bus.ready <= !hold_rsp && !(idle_on && $urandom_range(99) < 34);
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = '0;
      req_bus.char_code = '0;
      req_bus.attr_byte = '0;
      req_bus.bold = 1'b0;
      req_bus.cell_row = '0;
      req_bus.cell_col = '0;
      req_bus.erase_count = '0;
      rsp_bus.ready = 1'b0;
   end

   task automatic add_req(logic [2:0] k, logic [7:0] ch, logic [7:0] at, logic b,
                          logic [5:0] r, logic [6:0] c, logic [7:0] n);
      pending_reqs.push_back('{k, ch, at, b, r, c, n});
   endtask

   task automatic csr_write(logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {24'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      normal = value;
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_bus.valid && expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   // random request mostly shaped like console text
   task automatic add_random();
      int p;
      logic [7:0] ch;
      p = $urandom_range(99);
      ch = 8'($urandom_range(255));
      if (p < 40) ch = 8'($urandom_range(8'h20, 8'h7E));
      else if (p < 46) ch = CH_NEWLINE;
      else if (p < 50) ch = CH_TAB;
      if (p < 58)
         add_req(OP_PUT_CURSOR, ch, 8'($urandom), 1'($urandom), 6'($urandom),
                 7'($urandom), 8'($urandom));
      else if (p < 68)
         add_req(OP_PUT_CELL, ch, 8'($urandom), 1'($urandom), 6'($urandom_range(30)),
                 7'($urandom_range(90)), 8'($urandom));
      else if (p < 74)
         add_req(OP_ERASE, ch, 8'($urandom), 1'($urandom), 6'($urandom), 7'($urandom),
                 8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(6)));
      else if (p < 90)
         add_req(OP_READ, ch, 8'($urandom), 1'($urandom),
                 6'(($urandom_range(9) == 0) ? $urandom : $urandom_range(NROW-1)),
                 7'(($urandom_range(9) == 0) ? $urandom : $urandom_range(NCOL-1)),
                 8'($urandom));
      else if (p < 91)
         add_req(OP_CLEAR, ch, 8'($urandom), 1'($urandom), 6'($urandom), 7'($urandom),
                 8'($urandom));
      else if (p < 92)
         add_req(OP_FILL, ch, 8'($urandom), 1'($urandom), 6'($urandom), 7'($urandom),
                 8'($urandom));
      else if (p < 97)
         add_req(OP_SET_PEN, ch, 8'($urandom), 1'($urandom), 6'($urandom), 7'($urandom),
                 8'($urandom));
      else
         add_req(3'd7, ch, 8'($urandom), 1'($urandom), 6'($urandom), 7'($urandom),
                 8'($urandom));
   endtask

   // stimulus
   initial begin
      for (int i = 0; i < NCELL; i++) begin
         grid_ch[i] = CH_SPACE;
         grid_at[i] = RESET_ATTR;
      end
      crs_row = 0;
      crs_col = 0;
      pen = RESET_ATTR;
      normal = RESET_ATTR;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      csr_write(8'h00);
      // directed: extremes and special cases
      add_req(OP_CLEAR, 8'hFF, 8'hFF, 1'b1, 6'h3F, 7'h7F, 8'hFF);
      add_req(OP_READ, 0, 0, 0, 0, 0, 0);
      add_req(OP_READ, 0, 0, 0, 6'h3F, 7'h7F, 0);
      add_req(OP_PUT_CURSOR, 8'h20, 0, 1'b1, 0, 0, 0);
      add_req(OP_PUT_CURSOR, 8'h7E, 0, 0, 0, 0, 0);
      add_req(OP_PUT_CURSOR, 8'h80, 0, 0, 0, 0, 0);
      add_req(OP_PUT_CURSOR, 8'h8E, 0, 0, 0, 0, 0);
      add_req(OP_PUT_CURSOR, 8'h8F, 0, 0, 0, 0, 0);
      add_req(OP_PUT_CURSOR, 8'h1F, 0, 0, 0, 0, 0);
      add_req(OP_PUT_CURSOR, CH_TAB, 0, 1'b1, 0, 0, 0);
      add_req(OP_SET_PEN, 0, 8'hF0, 0, 0, 0, 0);
      add_req(OP_ERASE, 0, 0, 0, 0, 0, 8'hFF);
      add_req(OP_PUT_CELL, 8'h41, 8'hAA, 0, 6'(NROW-1), 7'(NCOL-1), 0);
      add_req(OP_PUT_CELL, 8'h41, 8'h55, 0, 6'(NROW), 0, 0);
      add_req(OP_PUT_CELL, 8'h7F, 8'h55, 0, 0, 0, 0);
      add_req(OP_READ, 0, 0, 0, 6'(NROW-1), 7'(NCOL-1), 0);
      for (int i = 0; i < NROW; i++) add_req(OP_PUT_CURSOR, CH_NEWLINE, 0, 0, 0, 0, 0);
      add_req(OP_FILL, 8'h23, 8'h1E, 0, 0, 0, 0);
      add_req(OP_FILL, 8'h00, 8'h1E, 0, 0, 0, 0);
      add_req(3'd7, 0, 0, 0, 0, 0, 0);
      drain();
      csr_write(8'hFF);
      add_req(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      // cursor to column COLS then tab and a deferred wrap
      for (int i = 0; i < NCOL; i++) add_req(OP_PUT_CURSOR, 8'h61, 0, 0, 0, 0, 0);
      add_req(OP_PUT_CURSOR, CH_TAB, 0, 0, 0, 0, 0);
      add_req(OP_READ, 0, 0, 0, 6'h3F, 7'h7F, 0);
      // receiver held off while the sender keeps going
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++) add_random();
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
      drain();
      csr_write(8'($urandom));
      // long stretch with no idling
      idle_on = 1'b0;
      for (int i = 0; i < 200; i++) add_random();
      drain();
      idle_on = 1'b1;
      csr_write(8'h07);
      for (int i = 0; i < 800; i++) add_random();
      drain();
      $display("covered %0d requests, %0d responses checked, including scrolls,",
               accepted, checked);
      $display("tabs, wraps, erases, fills, clears and out-of-grid reads");
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // limit on run time
   initial begin
      #400000000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// File: filelist.f
design/tcgw_pkg.sv
design/tcgw_if.sv
design/tcgw_front.sv
design/tcgw_back.sv
design/text_console_grid_writer.sv
tb/tb_top.sv
